// File: rtl/core/itl_pkg.sv
`default_nettype none

package itl_pkg;

    localparam int MAP_DEPTH  = 16;
    localparam int LINK_DEPTH = 64;

    localparam int MAP_AW  = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int MAP_CW  = $clog2(MAP_DEPTH + 1);
    localparam int LINK_AW = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
    localparam int LINK_CW = $clog2(LINK_DEPTH + 1);

    localparam logic [1:0] OP_MAP_INS  = 2'd0;
    localparam logic [1:0] OP_LINK_INS = 2'd1;
    localparam logic [1:0] OP_QUERY    = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  ptask;
        logic [7:0]  src_group;
        logic [15:0] task_req;
        logic [31:0] comm;
        logic [7:0]  target_group;
    } t_in_item;

    typedef struct packed {
        logic       status;
        logic [7:0] dest_app;
        logic       redirected;
    } t_out_item;

    typedef struct packed {
        logic [7:0] grp;
        logic [7:0] ptask;
    } t_map_entry;

    typedef struct packed {
        logic [7:0]  grp;
        logic [15:0] task_id;
        logic [31:0] comm;
        logic [7:0]  target_group;
    } t_link_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP_APP,
        S_LINK,
        S_MAP_GRP,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: rtl/core/itl_ifs.sv
`default_nettype none

interface itl_in_if;
    logic               valid;
    logic               ready;
    itl_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface itl_out_if;
    logic               valid;
    logic               ready;
    itl_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/intercomm_target_lookup_top.sv
// Insert and unused-op results go through the done state to the output register.
// A query with a nonzero task walks the map table, the link table and the map table again,
// one entry per cycle through the single read port of each table; it stops early
// on a miss or when the mapped group is zero.
// One transaction is in work at a time; the next waits until the result is moved to the output.
// Synchronous reset clears the entry counts and the handshakes; table contents are not cleared.
`default_nettype none

module intercomm_target_lookup_top (
    input  wire           i_clk,
    input  wire           i_rst_n,
    itl_in_if.sink        i_in,
    itl_out_if.source     o_out
);

    itl_pkg::t_state       r_state, n_state;

    logic [itl_pkg::MAP_CW-1:0]  r_map_cnt, n_map_cnt;
    logic [itl_pkg::LINK_CW-1:0] r_link_cnt, n_link_cnt;
    logic [itl_pkg::MAP_CW-1:0]  r_map_idx, n_map_idx;
    logic [itl_pkg::LINK_CW-1:0] r_link_idx, n_link_idx;
    logic                        r_pend, n_pend;

    logic [7:0]            r_app, n_app;
    logic [15:0]           r_task_m1, n_task_m1;
    logic [31:0]           r_comm, n_comm;
    logic [7:0]            r_grp, n_grp;
    itl_pkg::t_out_item    r_res, n_res;

    logic                  r_out_valid;
    itl_pkg::t_out_item    r_out;

    itl_pkg::t_map_entry   r_map_mem [itl_pkg::MAP_DEPTH];
    itl_pkg::t_link_entry  r_link_mem [itl_pkg::LINK_DEPTH];
    itl_pkg::t_map_entry   r_map_q;
    itl_pkg::t_link_entry  r_link_q;

    logic in_acc;
    logic out_free;
    logic map_full;
    logic link_full;
    logic map_end;
    logic link_end;
    logic hit_app;
    logic hit_link;
    logic hit_grp;
    logic map_wr;
    logic link_wr;

    assign in_acc    = i_in.valid && i_in.ready;
    assign map_full  = r_map_cnt >= itl_pkg::MAP_CW'(itl_pkg::MAP_DEPTH);
    assign link_full = r_link_cnt >= itl_pkg::LINK_CW'(itl_pkg::LINK_DEPTH);
    assign map_end   = r_map_idx >= r_map_cnt;
    assign link_end  = r_link_idx >= r_link_cnt;

    // The pending flag marks that the registered read data belongs to the scan in progress.
    assign hit_app  = r_pend && (r_map_q.ptask == r_app);
    assign hit_grp  = r_pend && (r_map_q.grp == r_grp);
    assign hit_link = r_pend && (r_link_q.grp == r_grp) && (r_link_q.task_id == r_task_m1)
                      && (r_link_q.comm == r_comm);

    assign map_wr  = in_acc && (i_in.data.op == itl_pkg::OP_MAP_INS) && !map_full;
    assign link_wr = in_acc && (i_in.data.op == itl_pkg::OP_LINK_INS) && !link_full;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            itl_pkg::S_IDLE: begin
                if (in_acc) begin
                    if ((i_in.data.op == itl_pkg::OP_QUERY) && (i_in.data.task_req != 16'd0)) begin
                        n_state = itl_pkg::S_MAP_APP;
                    end else begin
                        n_state = itl_pkg::S_DONE;
                    end
                end
            end
            itl_pkg::S_MAP_APP: begin
                if (hit_app) begin
                    n_state = (r_map_q.grp == 8'd0) ? itl_pkg::S_DONE : itl_pkg::S_LINK;
                end else if (map_end) begin
                    n_state = itl_pkg::S_DONE;
                end
            end
            itl_pkg::S_LINK: begin
                if (hit_link) begin
                    n_state = itl_pkg::S_MAP_GRP;
                end else if (link_end) begin
                    n_state = itl_pkg::S_DONE;
                end
            end
            itl_pkg::S_MAP_GRP: begin
                if (hit_grp || map_end) begin
                    n_state = itl_pkg::S_DONE;
                end
            end
            itl_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = itl_pkg::S_IDLE;
                end
            end
            default: n_state = itl_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer and datapath next values.
    always_comb begin
        i_in.ready = (r_state == itl_pkg::S_IDLE);
        out_free   = (r_state == itl_pkg::S_DONE) && (!r_out_valid || o_out.ready);

        n_map_cnt  = r_map_cnt;
        n_link_cnt = r_link_cnt;
        n_map_idx  = r_map_idx;
        n_link_idx = r_link_idx;
        n_pend     = r_pend;
        n_app      = r_app;
        n_task_m1  = r_task_m1;
        n_comm     = r_comm;
        n_grp      = r_grp;
        n_res      = r_res;

        case (r_state)
            itl_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_app      = i_in.data.ptask;
                    n_task_m1  = i_in.data.task_req - 16'd1;
                    n_comm     = i_in.data.comm;
                    n_map_idx  = '0;
                    n_link_idx = '0;
                    n_pend     = 1'b0;
                    n_res      = '0;
                    case (i_in.data.op)
                        itl_pkg::OP_MAP_INS: begin
                            if (map_full) begin
                                n_res.status = 1'b1;
                            end else begin
                                n_map_cnt = itl_pkg::MAP_CW'(r_map_cnt + 1'b1);
                            end
                        end
                        itl_pkg::OP_LINK_INS: begin
                            if (link_full) begin
                                n_res.status = 1'b1;
                            end else begin
                                n_link_cnt = itl_pkg::LINK_CW'(r_link_cnt + 1'b1);
                            end
                        end
                        itl_pkg::OP_QUERY: begin
                            n_res.dest_app = i_in.data.ptask;
                        end
                        default: n_res = '0;
                    endcase
                end
            end
            itl_pkg::S_MAP_APP, itl_pkg::S_MAP_GRP: begin
                if (!map_end) begin
                    n_map_idx = itl_pkg::MAP_CW'(r_map_idx + 1'b1);
                end
                n_pend = !map_end;
                if ((r_state == itl_pkg::S_MAP_APP) && hit_app) begin
                    n_grp = r_map_q.grp;
                end
                if ((r_state == itl_pkg::S_MAP_GRP) && hit_grp) begin
                    n_res.dest_app   = r_map_q.ptask;
                    n_res.redirected = 1'b1;
                end
            end
            itl_pkg::S_LINK: begin
                if (!link_end) begin
                    n_link_idx = itl_pkg::LINK_CW'(r_link_idx + 1'b1);
                end
                n_pend = !link_end;
                if (hit_link) begin
                    n_grp = r_link_q.target_group;
                end
            end
            default: begin
            end
        endcase

        // Every scan starts from the first entry with no read in flight.
        if ((r_state != itl_pkg::S_IDLE) && (n_state != r_state)) begin
            n_map_idx  = '0;
            n_link_idx = '0;
            n_pend     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itl_pkg::S_IDLE;
            r_map_cnt   <= '0;
            r_link_cnt  <= '0;
            r_map_idx   <= '0;
            r_link_idx  <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_map_cnt  <= n_map_cnt;
            r_link_cnt <= n_link_cnt;
            r_map_idx  <= n_map_idx;
            r_link_idx <= n_link_idx;
            r_pend     <= n_pend;
            if (out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_app     <= n_app;
        r_task_m1 <= n_task_m1;
        r_comm    <= n_comm;
        r_grp     <= n_grp;
        r_res     <= n_res;
        if (out_free) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_wr) begin
            r_map_mem[r_map_cnt[itl_pkg::MAP_AW-1:0]] <= '{grp: i_in.data.src_group,
                                                           ptask: i_in.data.ptask};
        end
        r_map_q <= r_map_mem[r_map_idx[itl_pkg::MAP_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (link_wr) begin
            r_link_mem[r_link_cnt[itl_pkg::LINK_AW-1:0]] <=
                '{grp: i_in.data.src_group, task_id: i_in.data.task_req,
                  comm: i_in.data.comm, target_group: i_in.data.target_group};
        end
        r_link_q <= r_link_mem[r_link_idx[itl_pkg::LINK_AW-1:0]];
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

`default_nettype wire

// File: rtl/core/itl_checker.sv
`default_nettype none

module itl_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire        i_out_status,
    input wire [7:0]  i_out_dest_app,
    input wire        i_out_redirected
);

    // The output register is empty right after reset.
    a_out_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // A transaction in work blocks the next one.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready held high right after an accepted transaction");

    // A dropped insert never carries query data.
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status |-> (i_out_dest_app == 8'd0) && !i_out_redirected)
        else $error("full status with nonzero query fields");

endmodule

bind intercomm_target_lookup_top itl_checker u_itl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_status     (o_out.data.status),
    .i_out_dest_app   (o_out.data.dest_app),
    .i_out_redirected (o_out.data.redirected)
);

`default_nettype wire
